@@ hdl/sgrl_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo goal rate limiter package
// Mode, torque change and register index codes, and the structures that pass
// the per-cycle decisions between the control and joint datapath modules.
// ----------------------------------------------------------------------------
package sgrl_pkg;

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_TELEOP = 2'd1;
  localparam logic [1:0] MODE_HOLD   = 2'd2;
  localparam logic [1:0] MODE_ESTOP  = 2'd3;

  localparam logic [1:0] CHG_NONE    = 2'd0;
  localparam logic [1:0] CHG_ENABLE  = 2'd1;
  localparam logic [1:0] CHG_DISABLE = 2'd2;

  localparam logic [1:0] REG_SOFT_STEP    = 2'd0;
  localparam logic [1:0] REG_RUN_STEP     = 2'd1;
  localparam logic [1:0] REG_SETTLE_TOL   = 2'd2;
  localparam logic [1:0] REG_RETRY_PERIOD = 2'd3;

  localparam logic [15:0] SOFT_STEP_RST    = 16'd5;
  localparam logic [15:0] RUN_STEP_RST     = 16'd100;
  localparam logic [15:0] SETTLE_TOL_RST   = 16'd10;
  localparam logic [15:0] RETRY_PERIOD_RST = 16'd50;
  localparam logic [15:0] STREAK_MAX       = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  mode;
    logic        torque;
    logic        refused;
    logic [15:0] streak;
    logic [31:0] cyc;
    logic [31:0] retry;
  } sgrl_ctrl_t;

  typedef struct packed {
    logic fok;
    logic lok;
    logic ena;
    logic hld;
  } sgrl_flags_t;

endpackage

@@ hdl/servo_goal_rate_limiter_with_modes_top.sv @@
// An accepted request is registered into stage 1 for the joint store read, and its result into the output registers.
// Throughput: one joint request per cycle while the result side does not stall, set by the single
// read-modify-write pass over the joint store (one read issued at acceptance, one write-back as stage 1 advances).
// Reset: synchronous; mode idle, torque off, counters zero, registers to their defaults,
// and per-entry valid bits make every goal and hold entry read as zero until first written.
// ----------------------------------------------------------------------------
// Servo goal rate limiter with modes
// Joint store in a RAM, cycle decisions on the first joint, rate-limited goal
// update with forwarding for back-to-back accesses to the same joint.
// ----------------------------------------------------------------------------
module servo_goal_rate_limiter_with_modes_top #(
  parameter int JOINTS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         mode_request,
  input  logic               follower_rd_ok,
  input  logic               leader_rd_ok,
  input  logic signed [15:0] follower_position,
  input  logic signed [15:0] leader_target,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] goal_position,
  output logic               goal_valid,
  output logic               torque_en,
  output logic [1:0]         torque_change,
  output logic [1:0]         mode_applied,
  output logic               ramping_flag,
  output logic               torque_refused,
  output logic               last_joint,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import sgrl_pkg::*;

  localparam int JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [JW-1:0] LAST_J = JW'(JOINTS - 1);

  logic [15:0] soft_step;
  logic [15:0] run_step;
  logic [15:0] settle_tol;
  logic [15:0] retry_period;

  sgrl_ctrl_t  ctrl;
  sgrl_ctrl_t  ctrl_next;
  sgrl_flags_t flags;
  sgrl_flags_t flags_next;
  logic [1:0]  change;
  logic [1:0]  change_next;
  logic        ramp_set;
  logic        ramp;
  logic [16:0] worst;
  logic [JW-1:0] joint_idx;

  logic        accept;
  logic        out_adv;
  logic        s1_adv;
  logic        first;
  logic        in_last;

  logic        s1_valid;
  logic [JW-1:0] s1_j;
  logic        s1_last;
  logic signed [15:0] s1_pos;
  logic signed [15:0] s1_lead;
  logic        s1_fwd;
  logic [31:0] s1_fwd_data;
  logic        s1_vld;

  logic [JOINTS-1:0] entry_vld;
  logic [31:0] rdata;
  logic [31:0] entry;
  logic [31:0] wdata;

  logic signed [15:0] goal_new;
  logic signed [15:0] hold_new;
  logic [16:0] worst_new;
  logic        ramp_clear;

  assign cfg_ready = 1'b1;
  assign out_adv   = !out_valid || out_ready;
  assign s1_adv    = s1_valid && out_adv;
  assign in_ready  = !s1_valid || out_adv;
  assign accept    = in_valid && in_ready;
  assign first     = (joint_idx == '0);
  assign in_last   = (joint_idx == LAST_J);

  always_ff @(posedge clk) begin
    if (rst) begin
      soft_step    <= SOFT_STEP_RST;
      run_step     <= RUN_STEP_RST;
      settle_tol   <= SETTLE_TOL_RST;
      retry_period <= RETRY_PERIOD_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOFT_STEP:    soft_step    <= cfg_data;
        REG_RUN_STEP:     run_step     <= cfg_data;
        REG_SETTLE_TOL:   settle_tol   <= cfg_data;
        REG_RETRY_PERIOD: retry_period <= cfg_data;
        default:          soft_step    <= soft_step;
      endcase
    end
  end

  sgrl_cycle u_cycle (
    .cur            (ctrl),
    .mode_request   (mode_request),
    .follower_rd_ok (follower_rd_ok),
    .leader_rd_ok   (leader_rd_ok),
    .retry_period   (retry_period),
    .nxt            (ctrl_next),
    .flags          (flags_next),
    .change         (change_next),
    .ramp_set       (ramp_set)
  );

  sgrl_ram #(
    .WIDTH (32),
    .DEPTH (JOINTS)
  ) u_store (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_j),
    .wdata (wdata),
    .re    (accept),
    .raddr (joint_idx),
    .rdata (rdata)
  );

  always_comb begin
    if (s1_fwd) begin
      entry = s1_fwd_data;
    end else if (s1_vld) begin
      entry = rdata;
    end else begin
      entry = '0;
    end
  end

  sgrl_joint u_joint (
    .flags     (flags),
    .torque    (ctrl.torque),
    .ramp      (ramp),
    .mode      (ctrl.mode),
    .soft_step (soft_step),
    .run_step  (run_step),
    .pos       (s1_pos),
    .lead      (s1_lead),
    .goal_rd   (entry[15:0]),
    .hold_rd   (entry[31:16]),
    .worst     (worst),
    .goal_new  (goal_new),
    .hold_new  (hold_new),
    .worst_new (worst_new)
  );

  assign wdata      = {hold_new, goal_new};
  assign ramp_clear = s1_last && ctrl.torque && ramp && (worst_new <= {1'b0, settle_tol});

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl      <= '0;
      flags     <= '0;
      change    <= CHG_NONE;
      ramp      <= 1'b0;
      worst     <= '0;
      joint_idx <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      entry_vld <= '0;
    end else begin
      if (s1_adv) begin
        entry_vld[s1_j] <= 1'b1;
      end
      if (accept && first) begin
        worst <= '0;
      end else if (s1_adv) begin
        worst <= worst_new;
      end
      if (accept && first && ramp_set) begin
        ramp <= 1'b1;
      end else if (s1_adv && ramp_clear) begin
        ramp <= 1'b0;
      end
      if (accept) begin
        joint_idx <= in_last ? '0 : joint_idx + JW'(1);
        if (first) begin
          ctrl   <= ctrl_next;
          flags  <= flags_next;
          change <= change_next;
        end
      end
      if (in_ready) begin
        s1_valid <= accept;
      end
      if (out_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_j        <= joint_idx;
      s1_last     <= in_last;
      s1_pos      <= follower_position;
      s1_lead     <= leader_target;
      s1_fwd      <= s1_adv && (s1_j == joint_idx);
      s1_fwd_data <= wdata;
      s1_vld      <= entry_vld[joint_idx];
    end
    if (s1_adv) begin
      goal_position  <= goal_new;
      goal_valid     <= ctrl.torque;
      torque_en      <= ctrl.torque;
      torque_change  <= change;
      mode_applied   <= ctrl.mode;
      ramping_flag   <= ctrl.torque && ramp && !ramp_clear;
      torque_refused <= ctrl.refused;
      last_joint     <= s1_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_enable_clears_fault : assert property (@(posedge clk) disable iff (rst)
    out_valid && torque_change == CHG_ENABLE |-> torque_en && !torque_refused)
    else $error("enable reported without torque on or with fault set");

  a_ramp_needs_torque : assert property (@(posedge clk) disable iff (rst)
    out_valid && ramping_flag |-> torque_en)
    else $error("ramping reported while torque is off");

  a_hold_needs_torque : assert property (@(posedge clk) disable iff (rst)
    s1_valid && flags.hld |-> ctrl.torque)
    else $error("hold latch requested while torque is off");
`endif

endmodule

@@ hdl/sgrl_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data; a read of the
// entry being written returns the old contents.
// ----------------------------------------------------------------------------
module sgrl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/sgrl_cycle.sv @@
// ----------------------------------------------------------------------------
// Cycle decision logic
// Evaluated on the first joint of a control cycle: failure streak, forced torque
// disable spaced by the retry period, and the idle/teleop/hold/estop mode machine with enable refusal.
// ----------------------------------------------------------------------------
module sgrl_cycle (
  input  sgrl_pkg::sgrl_ctrl_t  cur,
  input  logic [2:0]            mode_request,
  input  logic                  follower_rd_ok,
  input  logic                  leader_rd_ok,
  input  logic [15:0]           retry_period,
  output sgrl_pkg::sgrl_ctrl_t  nxt,
  output sgrl_pkg::sgrl_flags_t flags,
  output logic [1:0]            change,
  output logic                  ramp_set
);
  import sgrl_pkg::*;

  logic [15:0] every;
  logic [1:0]  req_m;

  assign every = (retry_period == 16'd0) ? 16'd1 : retry_period;

  always_comb begin
    nxt      = cur;
    flags    = '0;
    change   = CHG_NONE;
    ramp_set = 1'b0;
    req_m    = mode_request[2] ? MODE_IDLE : mode_request[1:0];

    nxt.cyc   = cur.cyc + 32'd1;
    flags.fok = follower_rd_ok;
    flags.lok = leader_rd_ok;

    if (follower_rd_ok) begin
      nxt.streak = '0;
    end else if (cur.streak != STREAK_MAX) begin
      nxt.streak = cur.streak + 16'd1;
    end

    if (nxt.streak >= every && nxt.cyc >= cur.retry) begin
      nxt.retry  = nxt.cyc + {16'd0, every};
      nxt.torque = 1'b0;
      change     = CHG_DISABLE;
    end

    if (req_m != cur.mode) begin
      if (req_m == MODE_TELEOP || req_m == MODE_HOLD) begin
        if (!nxt.torque) begin
          if (!follower_rd_ok) begin
            nxt.refused = 1'b1;
            req_m       = cur.mode;
          end else begin
            flags.ena   = 1'b1;
            nxt.torque  = 1'b1;
            change      = CHG_ENABLE;
            nxt.refused = 1'b0;
          end
        end
        if (req_m == MODE_HOLD && nxt.torque) begin
          flags.hld = 1'b1;
        end
      end else if (nxt.torque) begin
        nxt.torque = 1'b0;
        change     = CHG_DISABLE;
      end
      if (req_m != cur.mode && nxt.torque) begin
        ramp_set = 1'b1;
      end
      nxt.mode = req_m;
    end
  end

endmodule

@@ hdl/sgrl_joint.sv @@
// ----------------------------------------------------------------------------
// Joint goal update
// Picks the target of one joint, clamps the step toward it and tracks the
// worst joint error of the cycle.
// ----------------------------------------------------------------------------
module sgrl_joint (
  input  sgrl_pkg::sgrl_flags_t flags,
  input  logic                  torque,
  input  logic                  ramp,
  input  logic [1:0]            mode,
  input  logic [15:0]           soft_step,
  input  logic [15:0]           run_step,
  input  logic signed [15:0]    pos,
  input  logic signed [15:0]    lead,
  input  logic signed [15:0]    goal_rd,
  input  logic signed [15:0]    hold_rd,
  input  logic [16:0]           worst,
  output logic signed [15:0]    goal_new,
  output logic signed [15:0]    hold_new,
  output logic [16:0]           worst_new
);
  import sgrl_pkg::*;

  logic signed [15:0] g0;
  logic signed [15:0] target;
  logic signed [16:0] step;
  logic signed [16:0] d;
  logic signed [16:0] dc;
  logic signed [16:0] gsum;
  logic [16:0]        ad;

  assign g0       = flags.ena ? pos : goal_rd;
  assign hold_new = flags.hld ? (flags.fok ? pos : g0) : hold_rd;
  assign step     = $signed({1'b0, (ramp ? soft_step : run_step)});

  always_comb begin
    if (mode == MODE_TELEOP && flags.lok) begin
      target = lead;
    end else if (mode == MODE_HOLD) begin
      target = hold_new;
    end else begin
      target = g0;
    end
  end

  assign d  = 17'(target) - 17'(g0);
  assign ad = d[16] ? 17'(-d) : 17'(d);

  always_comb begin
    if (d > step) begin
      dc = step;
    end else if (d < -step) begin
      dc = -step;
    end else begin
      dc = d;
    end
  end

  assign gsum = 17'(g0) + dc;

  always_comb begin
    worst_new = worst;
    if (torque) begin
      goal_new = gsum[15:0];
      if (ad > worst) begin
        worst_new = ad;
      end
    end else if (flags.fok) begin
      goal_new = pos;
    end else begin
      goal_new = g0;
    end
  end

endmodule

@@ tb/servo_goal_rate_limiter_with_modes_checker.sv @@
// ----------------------------------------------------------------------------
// Servo goal rate limiter checker
// Watches the request, result and register write channels, predicts every
// joint result from its own copy of the mode, torque, ramp and goal state,
// and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module servo_goal_rate_limiter_with_modes_checker #(
  parameter int JOINTS = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         mode_request,
  input  logic               follower_rd_ok,
  input  logic               leader_rd_ok,
  input  logic signed [15:0] follower_position,
  input  logic signed [15:0] leader_target,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] goal_position,
  input  logic               goal_valid,
  input  logic               torque_en,
  input  logic [1:0]         torque_change,
  input  logic [1:0]         mode_applied,
  input  logic               ramping_flag,
  input  logic               torque_refused,
  input  logic               last_joint,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import sgrl_pkg::*;

  typedef struct packed {
    logic [15:0] goal;
    logic        gvalid;
    logic        torque;
    logic [1:0]  chg;
    logic [1:0]  mode;
    logic        ramping;
    logic        refused;
    logic        last;
  } joint_result_t;

  logic [15:0]   soft_step_q, run_step_q, settle_tol_q, reopen_q;
  int            goal_mem [JOINTS];
  int            hold_mem [JOINTS];
  logic [1:0]    mode_q;
  logic          torque_q, ramp_q, refused_q;
  logic [15:0]   streak_q;
  logic [31:0]   cyc_q, retry_q;
  int            worst_q;
  int            joint_q;
  sgrl_flags_t   flags_q;
  logic [1:0]    chg_q;
  joint_result_t goal_queue [$];
  int            accepted_n = 0;
  int            returned_n = 0;
  int            mismatch_n = 0;

  assign outstanding = accepted_n - returned_n;
  assign fail_count  = mismatch_n;

  function automatic joint_result_t predict_joint(input logic [2:0] req_in, input logic fok,
                                                  input logic lok, input int pos, input int lead);
    logic [1:0]    req;
    logic [15:0]   every;
    int            g, tgt, d, ad, step;
    joint_result_t r;
    if (joint_q == 0) begin
      every = (reopen_q == 16'd0) ? 16'd1 : reopen_q;
      cyc_q = cyc_q + 32'd1;
      flags_q = '0;
      flags_q.fok = fok;
      flags_q.lok = lok;
      chg_q = CHG_NONE;
      worst_q = 0;
      if (fok) begin
        streak_q = '0;
      end else if (streak_q != STREAK_MAX) begin
        streak_q = streak_q + 16'd1;
      end
      if (streak_q >= every && cyc_q >= retry_q) begin
        retry_q = cyc_q + {16'd0, every};
        torque_q = 1'b0;
        chg_q = CHG_DISABLE;
      end
      req = (req_in > 3'd3) ? MODE_IDLE : req_in[1:0];
      if (req != mode_q) begin
        if (req == MODE_TELEOP || req == MODE_HOLD) begin
          if (!torque_q) begin
            if (!fok) begin
              refused_q = 1'b1;
              req = mode_q;
            end else begin
              flags_q.ena = 1'b1;
              torque_q = 1'b1;
              chg_q = CHG_ENABLE;
              refused_q = 1'b0;
            end
          end
          if (req == MODE_HOLD && torque_q) flags_q.hld = 1'b1;
        end else if (torque_q) begin
          torque_q = 1'b0;
          chg_q = CHG_DISABLE;
        end
        if (req != mode_q && torque_q) ramp_q = 1'b1;
        mode_q = req;
      end
    end
    if (flags_q.ena) goal_mem[joint_q] = pos;
    if (flags_q.hld) hold_mem[joint_q] = flags_q.fok ? pos : goal_mem[joint_q];
    g = goal_mem[joint_q];
    if (torque_q) begin
      step = ramp_q ? {16'd0, soft_step_q} : {16'd0, run_step_q};
      tgt = g;
      if (mode_q == MODE_TELEOP && flags_q.lok) begin
        tgt = lead;
      end else if (mode_q == MODE_HOLD) begin
        tgt = hold_mem[joint_q];
      end
      d = tgt - g;
      ad = (d < 0) ? -d : d;
      if (ad > worst_q) worst_q = ad;
      if (d > step) d = step;
      if (d < -step) d = -step;
      g = g + d;
      goal_mem[joint_q] = g;
    end else if (flags_q.fok) begin
      g = pos;
      goal_mem[joint_q] = g;
    end
    r.last = (joint_q == JOINTS - 1);
    if (r.last) begin
      if (torque_q && ramp_q && worst_q <= int'({16'd0, settle_tol_q})) ramp_q = 1'b0;
      joint_q = 0;
    end else begin
      joint_q = joint_q + 1;
    end
    r.goal    = g[15:0];
    r.gvalid  = torque_q;
    r.torque  = torque_q;
    r.chg     = chg_q;
    r.mode    = mode_q;
    r.ramping = torque_q && ramp_q;
    r.refused = refused_q;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    joint_result_t seen, want;
    int            k;
    if (rst) begin
      soft_step_q  = SOFT_STEP_RST;
      run_step_q   = RUN_STEP_RST;
      settle_tol_q = SETTLE_TOL_RST;
      reopen_q     = RETRY_PERIOD_RST;
      for (k = 0; k < JOINTS; k++) begin
        goal_mem[k] = 0;
        hold_mem[k] = 0;
      end
      mode_q    = MODE_IDLE;
      torque_q  = 1'b0;
      ramp_q    = 1'b0;
      refused_q = 1'b0;
      streak_q  = '0;
      cyc_q     = '0;
      retry_q   = '0;
      worst_q   = 0;
      joint_q   = 0;
      flags_q   = '0;
      chg_q     = CHG_NONE;
      goal_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        seen.goal    = goal_position;
        seen.gvalid  = goal_valid;
        seen.torque  = torque_en;
        seen.chg     = torque_change;
        seen.mode    = mode_applied;
        seen.ramping = ramping_flag;
        seen.refused = torque_refused;
        seen.last    = last_joint;
        if (goal_queue.size() == 0) begin
          if (mismatch_n < 10) begin
            $display("%0t: result with no request waiting: goal %0d", $realtime,
                     $signed(seen.goal));
          end
          mismatch_n <= mismatch_n + 1;
        end else begin
          want = goal_queue.pop_front();
          returned_n <= returned_n + 1;
          if (want !== seen) begin
            if (mismatch_n < 10) begin
              $display({"%0t: result %0d: expected goal %0d valid %0b torque %0b change %0d ",
                        "mode %0d ramping %0b refused %0b last %0b"}, $realtime, returned_n,
                       $signed(want.goal), want.gvalid, want.torque, want.chg, want.mode,
                       want.ramping, want.refused, want.last);
              $display({"%0t: result %0d: actual   goal %0d valid %0b torque %0b change %0d ",
                        "mode %0d ramping %0b refused %0b last %0b"}, $realtime, returned_n,
                       $signed(seen.goal), seen.gvalid, seen.torque, seen.chg, seen.mode,
                       seen.ramping, seen.refused, seen.last);
            end
            mismatch_n <= mismatch_n + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOFT_STEP: begin
            soft_step_q = cfg_data;
          end
          REG_RUN_STEP: begin
            run_step_q = cfg_data;
          end
          REG_SETTLE_TOL: begin
            settle_tol_q = cfg_data;
          end
          REG_RETRY_PERIOD: begin
            reopen_q = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) begin
        goal_queue.push_back(predict_joint(mode_request, follower_rd_ok, leader_rd_ok,
                                           follower_position, leader_target));
        accepted_n <= accepted_n + 1;
      end
    end
  end

endmodule

@@ tb/servo_goal_rate_limiter_with_modes_top_tb.sv @@
// ----------------------------------------------------------------------------
// Servo goal rate limiter testbench
// Drives joint requests, whole control cycles at a time, through a short
// directed sequence and then phases of random cycles under several register
// settings, with random gaps and stalls on both channels and one long stall
// of the result side. The checker alongside the block predicts and compares.
// ----------------------------------------------------------------------------
module servo_goal_rate_limiter_with_modes_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sgrl_pkg::*;

  localparam int JOINTS      = 6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD   = 80;
  localparam int PHASES      = 8;
  localparam int PHASE_LEN   = 30;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         mode_request = '0;
  logic               follower_rd_ok = 1'b0;
  logic               leader_rd_ok = 1'b0;
  logic signed [15:0] follower_position = '0;
  logic signed [15:0] leader_target = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] goal_position;
  logic               goal_valid;
  logic               torque_en;
  logic [1:0]         torque_change;
  logic [1:0]         mode_applied;
  logic               ramping_flag;
  logic               torque_refused;
  logic               last_joint;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [15:0]        cfg_data = '0;
  int                 fail_count;
  int                 outstanding;

  bit                 tx_fast = 1'b0;
  bit                 rx_fast = 1'b0;
  bit                 rx_hold = 1'b0;
  bit                 hold_go = 1'b0;
  logic [2:0]         cur_req = '0;
  int                 fail_left = 0;
  int                 centre [JOINTS];

  servo_goal_rate_limiter_with_modes_top #(.JOINTS(JOINTS)) dut (.*);

  servo_goal_rate_limiter_with_modes_checker #(.JOINTS(JOINTS)) goal_check (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_item(input logic [2:0] req, input logic fok, input logic lok,
                           input logic [15:0] pos, input logic [15:0] lead);
    int n;
    n = tx_fast ? 0 : $urandom_range(0, 9);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid          <= 1'b1;
    mode_request      <= req;
    follower_rd_ok    <= fok;
    leader_rd_ok      <= lok;
    follower_position <= pos;
    leader_target     <= lead;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_cycle();
    bit         tidy;
    logic [2:0] req;
    logic       fok, lok;
    int         j, p, l, spread;
    tidy = ($urandom_range(0, 9) < 8);
    if (tidy) begin
      if ($urandom_range(0, 99) < 15) begin
        cur_req = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                               : 3'($urandom_range(0, 3));
      end
      req = cur_req;
      if (fail_left > 0) begin
        fok = 1'b0;
        fail_left--;
      end else begin
        fok = ($urandom_range(0, 99) >= 8);
        if ($urandom_range(0, 99) < 5) fail_left = $urandom_range(1, 6);
      end
      lok = ($urandom_range(0, 99) >= 10);
    end else begin
      req = 3'($urandom);
      fok = 1'($urandom);
      lok = 1'($urandom);
    end
    spread = $urandom_range(0, 12);
    for (j = 0; j < JOINTS; j++) begin
      if (tidy) begin
        if ($urandom_range(0, 99) < 5) begin
          centre[j] = int'($urandom_range(0, 65534)) - 32767;
        end else begin
          centre[j] = centre[j] + int'($urandom_range(0, 6)) - 3;
        end
        p = centre[j] + int'($urandom_range(0, 32)) - 16;
        l = centre[j] + int'($urandom_range(0, 2 * spread)) - spread;
        if (p < -32767) p = -32767;
        if (p > 32767) p = 32767;
        if (l < -32768) l = -32768;
        if (l > 32767) l = 32767;
      end else begin
        p = int'($urandom_range(0, 65534)) - 32767;
        l = int'($urandom_range(0, 65535)) - 32768;
      end
      if (j == 0) begin
        send_item(req, fok, lok, p[15:0], l[15:0]);
      end else begin
        send_item(3'($urandom), 1'($urandom), 1'($urandom), p[15:0], l[15:0]);
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic wait_drain();
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Result side: a random stall before each result, or a long hold-off when asked.
  initial begin : receiver
    int n;
    while (rst) @(posedge clk);
    forever begin
      n = rx_fast ? 0 : $urandom_range(0, 9);
      if (n > 0 || rx_hold) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        while (rx_hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin : long_hold
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** servo_goal_rate_limiter_with_modes_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] cfg_table [PHASES][4];
    int          extreme_pos [JOINTS];
    int          extreme_lead [JOINTS];
    int          ph, c, j;
    cfg_table = '{'{16'd5, 16'd100, 16'd10, 16'd50},
                  '{16'd0, 16'd0, 16'd0, 16'd1},
                  '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
                  '{16'd1, 16'd3, 16'd2, 16'd0},
                  '{16'd3, 16'd50, 16'd20, 16'd2},
                  '{16'd20, 16'd400, 16'd100, 16'd3},
                  '{16'd0, 16'd0, 16'd0, 16'd0},
                  '{16'd8, 16'd1000, 16'd5, 16'd4}};
    extreme_pos  = '{-32767, 32767, 0, 1, -1, 12345};
    extreme_lead = '{32767, -32768, 0, -1, 1, -12345};
    for (j = 0; j < JOINTS; j++) centre[j] = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Refused enable, enable straight into hold, teleop with the leader read
    // failed, then an out-of-range request that falls back to idle.
    for (j = 0; j < JOINTS; j++) begin
      send_item({1'b0, MODE_TELEOP}, 1'b0, 1'b1, extreme_pos[j][15:0], extreme_lead[j][15:0]);
    end
    for (j = 0; j < JOINTS; j++) begin
      send_item({1'b0, MODE_HOLD}, 1'b1, 1'b0, extreme_pos[j][15:0], extreme_lead[j][15:0]);
    end
    for (j = 0; j < JOINTS; j++) begin
      send_item({1'b0, MODE_TELEOP}, 1'b1, 1'b0, extreme_lead[j][15:0], extreme_pos[j][15:0]);
    end
    for (j = 0; j < JOINTS; j++) begin
      send_item(3'd7, 1'b1, 1'b1, extreme_pos[j][15:0], extreme_lead[j][15:0]);
    end

    for (ph = 0; ph < PHASES; ph++) begin
      in_valid <= 1'b0;
      wait_drain();
      if (ph == 6) begin
        cfg_table[ph][0] = 16'($urandom_range(0, 200));
        cfg_table[ph][1] = 16'($urandom_range(0, 2000));
        cfg_table[ph][2] = 16'($urandom_range(0, 200));
        cfg_table[ph][3] = 16'($urandom_range(1, 8));
      end
      write_reg(REG_SOFT_STEP, cfg_table[ph][0]);
      write_reg(REG_RUN_STEP, cfg_table[ph][1]);
      write_reg(REG_SETTLE_TOL, cfg_table[ph][2]);
      write_reg(REG_RETRY_PERIOD, cfg_table[ph][3]);
      cfg_valid <= 1'b0;
      tx_fast = (ph == 2 || ph == 5);
      rx_fast = (ph == 1 || ph == 5);
      if (ph == 4) hold_go = 1'b1;
      for (c = 0; c < PHASE_LEN; c++) send_cycle();
    end
    in_valid <= 1'b0;
    wait_drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("** servo_goal_rate_limiter_with_modes_top: PASSED **");
    end else begin
      $display("** servo_goal_rate_limiter_with_modes_top: FAILED **");
    end
    $finish;
  end

endmodule
